/* rtl/rri_pkg.sv */
// Shared types, codes and widths for the ray/rectangle intersection block.
`default_nettype none
package rri_pkg;
    localparam int CW = 32;   // coordinate width
    localparam int OW = 33;   // multiplier operand width
    localparam int PW = 66;   // product width
    localparam int AW = 68;   // accumulator / cross product width
    localparam int KW = 31;   // quotient width, Q1.30
    localparam int QW = 32;   // raw quotient bits

    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_X   = 3'd2;
    localparam logic [2:0] CFG_SIZE_Y   = 3'd3;
    localparam logic [2:0] CFG_COS      = 3'd4;
    localparam logic [2:0] CFG_SIN      = 3'd5;

    localparam logic [3:0] M_NONE    = 4'd0;
    localparam logic [3:0] M_COS_LX  = 4'd1;
    localparam logic [3:0] M_SIN_LY  = 4'd2;
    localparam logic [3:0] M_SIN_LX  = 4'd3;
    localparam logic [3:0] M_COS_LY  = 4'd4;
    localparam logic [3:0] M_DX1_DY2 = 4'd5;
    localparam logic [3:0] M_DY1_DX2 = 4'd6;
    localparam logic [3:0] M_DX2_WY  = 4'd7;
    localparam logic [3:0] M_DY2_WX  = 4'd8;
    localparam logic [3:0] M_DX1_WY  = 4'd9;
    localparam logic [3:0] M_DY1_WX  = 4'd10;
    localparam logic [3:0] M_DX1_UQ  = 4'd11;
    localparam logic [3:0] M_DY1_UQ  = 4'd12;

    localparam logic [1:0] A_NONE = 2'd0;
    localparam logic [1:0] A_LOAD = 2'd1;
    localparam logic [1:0] A_ADD  = 2'd2;
    localparam logic [1:0] A_SUB  = 2'd3;

    localparam logic [3:0] ST_NONE = 4'd0;
    localparam logic [3:0] ST_RAY  = 4'd1;
    localparam logic [3:0] ST_CX   = 4'd2;
    localparam logic [3:0] ST_CY   = 4'd3;
    localparam logic [3:0] ST_AX   = 4'd4;
    localparam logic [3:0] ST_AY   = 4'd5;
    localparam logic [3:0] ST_BX   = 4'd6;
    localparam logic [3:0] ST_BY   = 4'd7;
    localparam logic [3:0] ST_DEN  = 4'd8;
    localparam logic [3:0] ST_NU   = 4'd9;
    localparam logic [3:0] ST_NV   = 4'd10;
    localparam logic [3:0] ST_NORM = 4'd11;
    localparam logic [3:0] ST_UQ   = 4'd12;
    localparam logic [3:0] ST_HX   = 4'd13;
    localparam logic [3:0] ST_HY   = 4'd14;
    localparam logic [3:0] ST_KEY  = 4'd15;

    localparam logic [1:0] OUT_POINT = 2'd0;
    localparam logic [1:0] OUT_NOHIT = 2'd1;
    localparam logic [1:0] OUT_ERROR = 2'd2;

    typedef struct packed {
        logic [3:0] msel;
        logic [1:0] aop;
        logic [3:0] st;
        logic [1:0] k;
        logic       div_start;
        logic       div_sel_v;
        logic       sort_en;
        logic       sort_odd;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
        logic [1:0] emit;
    } t_cmd;

    typedef struct packed {
        logic       den_zero;
        logic       in_range;
        logic       div_busy;
        logic       div_done;
        logic [2:0] hit_count;
        logic       sorted;
        logic       out_free;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/rri_div.sv */
// Restoring fraction divider, one quotient bit per cycle, rounded half up.
`default_nettype none
module rri_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [rri_pkg::AW-2:0]   i_num,
    input  wire logic [rri_pkg::AW-2:0]   i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [rri_pkg::KW-1:0]        o_quot
);
    logic [rri_pkg::AW-1:0] r_rem;
    logic [rri_pkg::AW-2:0] r_den;
    logic [rri_pkg::QW-1:0] r_q;
    logic [4:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [rri_pkg::AW-1:0] w_trial;
    logic                   w_ge;
    logic [rri_pkg::QW:0]   w_q1;

    always_comb begin
        w_trial = (r_cnt == 5'd0) ? r_rem : {r_rem[rri_pkg::AW-2:0], 1'b0};
        w_ge    = w_trial >= {1'b0, r_den};
        w_q1    = {1'b0, r_q} + {{rri_pkg::QW{1'b0}}, 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
                r_q   <= {r_q[rri_pkg::QW-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(rri_pkg::QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = w_q1[rri_pkg::KW:1];
endmodule
`default_nettype wire

/* rtl/rri_datapath.sv */
// Datapath: configuration, corner store, shared multiplier, cross products, hit slots, output.
`default_nettype none
module rri_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rri_pkg::t_cmd i_cmd,
    output rri_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_valid,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [127:0]  i_s_tdata,
    input  wire logic [0:0]    i_s_tuser,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [71:0]        o_m_tdata,
    output logic [1:0]         o_m_tuser,
    output logic               o_m_tlast
);
    localparam int CW = rri_pkg::CW;
    localparam int OW = rri_pkg::OW;
    localparam int AW = rri_pkg::AW;
    localparam int KW = rri_pkg::KW;

    function automatic logic signed [AW-1:0] f_rnd(input logic signed [AW-1:0] v,
                                                   input int unsigned n);
        logic [AW-1:0] mag;
        logic [AW-1:0] r;
        mag = v[AW-1] ? AW'(-v) : AW'(v);
        r   = (mag + (AW'(1) << (n - 1))) >> n;
        return v[AW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [CW-1:0] f_sat(input logic signed [AW-1:0] v);
        if ((&v[AW-1:CW-1]) || !(|v[AW-1:CW-1])) return v[CW-1:0];
        return v[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] f_ext(input logic signed [CW-1:0] v);
        return {{(AW-CW){v[CW-1]}}, v};
    endfunction

    logic signed [31:0] r_cx, r_cy;
    logic [30:0]        r_sx, r_sy;
    logic signed [17:0] r_cos, r_sin;
    logic signed [31:0] r_px, r_py;
    logic signed [OW-1:0] r_dx2, r_dy2;
    logic               r_sort;
    logic signed [31:0] r_corner [8];
    logic signed [31:0] r_ax, r_ay;
    logic signed [OW-1:0] r_dx1, r_dy1, r_wx, r_wy;
    logic signed [AW-1:0] r_prod, r_acc, r_den, r_nu, r_nv;
    logic [KW-1:0]      r_uq;
    logic [31:0]        r_hx, r_hy;
    logic [31:0]        r_shx [4];
    logic [31:0]        r_shy [4];
    logic [KW-1:0]      r_skey [4];
    logic [1:0]         r_sb [4];
    logic [2:0]         r_n;
    logic               r_ov;
    logic [31:0]        r_ox, r_oy;
    logic [1:0]         r_ob, r_oc;
    logic               r_ol;

    logic [2:0]           w_rd_idx;
    logic signed [31:0]   w_rd;
    logic [1:0]           w_nb;
    logic signed [OW-1:0] w_szx, w_szy, w_lx, w_ly, w_cos, w_sin, w_uq;
    logic signed [OW-1:0] w_ma, w_mb;
    logic signed [rri_pkg::PW-1:0] w_mp;
    logic [AW-2:0]        w_dnum;
    logic                 w_dbusy, w_ddone;
    logic [KW-1:0]        w_dq;

    always_comb begin
        w_nb = i_cmd.k + 2'd1;
        case (i_cmd.st)
            rri_pkg::ST_AX: w_rd_idx = {i_cmd.k, 1'b0};
            rri_pkg::ST_AY: w_rd_idx = {i_cmd.k, 1'b1};
            rri_pkg::ST_BX: w_rd_idx = {w_nb, 1'b0};
            default:        w_rd_idx = {w_nb, 1'b1};
        endcase
        w_rd  = r_corner[w_rd_idx];
        w_szx = $signed({2'b00, r_sx});
        w_szy = $signed({2'b00, r_sy});
        w_lx  = (i_cmd.k == 2'd1 || i_cmd.k == 2'd2) ? w_szx : -w_szx;
        w_ly  = i_cmd.k[1] ? w_szy : -w_szy;
        w_cos = {{(OW-18){r_cos[17]}}, r_cos};
        w_sin = {{(OW-18){r_sin[17]}}, r_sin};
        w_uq  = $signed({{(OW-KW){1'b0}}, r_uq});
        case (i_cmd.msel)
            rri_pkg::M_COS_LX:  begin w_ma = w_cos; w_mb = w_lx;  end
            rri_pkg::M_SIN_LY:  begin w_ma = w_sin; w_mb = w_ly;  end
            rri_pkg::M_SIN_LX:  begin w_ma = w_sin; w_mb = w_lx;  end
            rri_pkg::M_COS_LY:  begin w_ma = w_cos; w_mb = w_ly;  end
            rri_pkg::M_DX1_DY2: begin w_ma = r_dx1; w_mb = r_dy2; end
            rri_pkg::M_DY1_DX2: begin w_ma = r_dy1; w_mb = r_dx2; end
            rri_pkg::M_DX2_WY:  begin w_ma = r_dx2; w_mb = r_wy;  end
            rri_pkg::M_DY2_WX:  begin w_ma = r_dy2; w_mb = r_wx;  end
            rri_pkg::M_DX1_WY:  begin w_ma = r_dx1; w_mb = r_wy;  end
            rri_pkg::M_DY1_WX:  begin w_ma = r_dy1; w_mb = r_wx;  end
            rri_pkg::M_DX1_UQ:  begin w_ma = r_dx1; w_mb = w_uq;  end
            rri_pkg::M_DY1_UQ:  begin w_ma = r_dy1; w_mb = w_uq;  end
            default:            begin w_ma = '0;    w_mb = '0;    end
        endcase
        w_mp   = w_ma * w_mb;
        w_dnum = i_cmd.div_sel_v ? r_nv[AW-2:0] : r_nu[AW-2:0];
    end

    rri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_dnum),
        .i_den   (r_den[AW-2:0]),
        .o_busy  (w_dbusy),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_sx  <= 31'd65536;
            r_sy  <= 31'd65536;
            r_cos <= 18'sd65536;
            r_sin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rri_pkg::CFG_CENTER_X: r_cx  <= i_cfg_data;
                rri_pkg::CFG_CENTER_Y: r_cy  <= i_cfg_data;
                rri_pkg::CFG_SIZE_X:   r_sx  <= i_cfg_data[30:0];
                rri_pkg::CFG_SIZE_Y:   r_sy  <= i_cfg_data[30:0];
                rri_pkg::CFG_COS:      r_cos <= i_cfg_data[17:0];
                rri_pkg::CFG_SIN:      r_sin <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // arithmetic and working registers
    always_ff @(posedge i_clk) begin
        r_prod <= {{(AW-rri_pkg::PW){w_mp[rri_pkg::PW-1]}}, w_mp};
        case (i_cmd.aop)
            rri_pkg::A_LOAD: r_acc <= r_prod;
            rri_pkg::A_ADD:  r_acc <= r_acc + r_prod;
            rri_pkg::A_SUB:  r_acc <= r_acc - r_prod;
            default: ;
        endcase
        case (i_cmd.st)
            rri_pkg::ST_RAY: begin
                r_px   <= i_s_tdata[31:0];
                r_py   <= i_s_tdata[63:32];
                r_dx2  <= $signed({i_s_tdata[95], i_s_tdata[95:64]})
                        - $signed({i_s_tdata[31], i_s_tdata[31:0]});
                r_dy2  <= $signed({i_s_tdata[127], i_s_tdata[127:96]})
                        - $signed({i_s_tdata[63], i_s_tdata[63:32]});
                r_sort <= i_s_tuser[0];
            end
            rri_pkg::ST_CX: r_corner[{i_cmd.k, 1'b0}] <= f_sat(f_ext(r_cx) + f_rnd(r_acc, 17));
            rri_pkg::ST_CY: r_corner[{i_cmd.k, 1'b1}] <= f_sat(f_ext(r_cy) + f_rnd(r_acc, 17));
            rri_pkg::ST_AX: r_ax <= w_rd;
            rri_pkg::ST_AY: r_ay <= w_rd;
            rri_pkg::ST_BX: begin
                r_dx1 <= $signed({w_rd[31], w_rd}) - $signed({r_ax[31], r_ax});
                r_wx  <= $signed({r_ax[31], r_ax}) - $signed({r_px[31], r_px});
            end
            rri_pkg::ST_BY: begin
                r_dy1 <= $signed({w_rd[31], w_rd}) - $signed({r_ay[31], r_ay});
                r_wy  <= $signed({r_ay[31], r_ay}) - $signed({r_py[31], r_py});
            end
            rri_pkg::ST_DEN: r_den <= r_acc;
            rri_pkg::ST_NU:  r_nu  <= r_acc;
            rri_pkg::ST_NV:  r_nv  <= r_acc;
            rri_pkg::ST_NORM: begin
                if (r_den[AW-1]) begin
                    r_den <= -r_den;
                    r_nu  <= -r_nu;
                    r_nv  <= -r_nv;
                end
            end
            rri_pkg::ST_UQ: r_uq <= w_dq;
            rri_pkg::ST_HX: r_hx <= f_sat(f_ext(r_ax) + f_rnd(r_prod, 30));
            rri_pkg::ST_HY: r_hy <= f_sat(f_ext(r_ay) + f_rnd(r_prod, 30));
            rri_pkg::ST_KEY: begin
                r_shx[r_n[1:0]]  <= r_hx;
                r_shy[r_n[1:0]]  <= r_hy;
                r_skey[r_n[1:0]] <= w_dq;
                r_sb[r_n[1:0]]   <= i_cmd.k;
            end
            default: ;
        endcase
        // odd-even transposition, strict compare keeps border order on ties
        if (i_cmd.sort_en) begin
            for (int i = 0; i < 3; i++) begin
                if (((i == 1) == i_cmd.sort_odd) && (3'(i + 1) < r_n)
                        && (r_skey[i+1] < r_skey[i])) begin
                    r_shx[i]    <= r_shx[i+1];
                    r_shx[i+1]  <= r_shx[i];
                    r_shy[i]    <= r_shy[i+1];
                    r_shy[i+1]  <= r_shy[i];
                    r_skey[i]   <= r_skey[i+1];
                    r_skey[i+1] <= r_skey[i];
                    r_sb[i]     <= r_sb[i+1];
                    r_sb[i+1]   <= r_sb[i];
                end
            end
        end
        if (i_cmd.out_load) begin
            r_ol <= i_cmd.out_last;
            r_oc <= i_cmd.out_kind;
            if (i_cmd.out_kind == rri_pkg::OUT_POINT) begin
                r_ox <= r_shx[i_cmd.emit];
                r_oy <= r_shy[i_cmd.emit];
                r_ob <= r_sb[i_cmd.emit];
            end else begin
                r_ox <= '0;
                r_oy <= '0;
                r_ob <= (i_cmd.out_kind == rri_pkg::OUT_ERROR) ? i_cmd.k : 2'd0;
            end
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.st == rri_pkg::ST_RAY) r_n <= '0;
            else if (i_cmd.st == rri_pkg::ST_KEY) r_n <= r_n + 3'd1;
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
        end
    end

    always_comb begin
        o_sts.den_zero  = (r_den == '0);
        o_sts.in_range  = !r_nu[AW-1] && !r_nv[AW-1] && (r_nu <= r_den) && (r_nv <= r_den);
        o_sts.div_busy  = w_dbusy;
        o_sts.div_done  = w_ddone;
        o_sts.hit_count = r_n;
        o_sts.sorted    = r_sort;
        o_sts.out_free  = !r_ov || i_m_tready;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {6'd0, r_ob, r_oy, r_ox};
    assign o_m_tuser  = r_oc;
    assign o_m_tlast  = r_ol;
endmodule
`default_nettype wire

/* rtl/rri_ctrl.sv */
// Controller: sequences corner build, per-border solve, division, sort and result words.
`default_nettype none
module rri_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic          i_cfg_valid,
    input  wire rri_pkg::t_sts i_sts,
    output rri_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_BUILD = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BORD  = 4'd2;
    localparam logic [3:0] S_DIVU  = 4'd3;
    localparam logic [3:0] S_HIT   = 4'd4;
    localparam logic [3:0] S_DIVV  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_SORT  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_pc, n_pc;
    logic [1:0] r_k, n_k;
    logic [1:0] r_emit, n_emit;
    logic [1:0] r_kind, n_kind;

    always_comb begin
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_cmd.emit = r_emit;
        n_state    = r_state;
        n_pc       = r_pc + 4'd1;
        n_k        = r_k;
        n_emit     = r_emit;
        n_kind     = r_kind;
        o_s_tready = (r_state == S_IDLE) && !i_cfg_valid;
        case (r_state)
            S_BUILD: begin
                case (r_pc)
                    4'd0: o_cmd.msel = rri_pkg::M_COS_LX;
                    4'd1: begin o_cmd.msel = rri_pkg::M_SIN_LY; o_cmd.aop = rri_pkg::A_LOAD; end
                    4'd2: o_cmd.aop = rri_pkg::A_SUB;
                    4'd3: o_cmd.st = rri_pkg::ST_CX;
                    4'd4: o_cmd.msel = rri_pkg::M_SIN_LX;
                    4'd5: begin o_cmd.msel = rri_pkg::M_COS_LY; o_cmd.aop = rri_pkg::A_LOAD; end
                    4'd6: o_cmd.aop = rri_pkg::A_ADD;
                    default: o_cmd.st = rri_pkg::ST_CY;
                endcase
                if (r_pc == 4'd7) begin
                    n_pc = '0;
                    n_k  = r_k + 2'd1;
                    if (r_k == 2'd3) n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_pc = '0;
                if (i_s_tvalid && o_s_tready) begin
                    o_cmd.st = rri_pkg::ST_RAY;
                    n_state  = S_BORD;
                    n_k      = '0;
                end
            end
            S_BORD: begin
                case (r_pc)
                    4'd0: o_cmd.st = rri_pkg::ST_AX;
                    4'd1: o_cmd.st = rri_pkg::ST_AY;
                    4'd2: o_cmd.st = rri_pkg::ST_BX;
                    4'd3: o_cmd.st = rri_pkg::ST_BY;
                    4'd4: o_cmd.msel = rri_pkg::M_DX1_DY2;
                    4'd5: begin o_cmd.msel = rri_pkg::M_DY1_DX2; o_cmd.aop = rri_pkg::A_LOAD; end
                    4'd6: begin o_cmd.msel = rri_pkg::M_DX2_WY;  o_cmd.aop = rri_pkg::A_SUB;  end
                    4'd7: begin
                        o_cmd.msel = rri_pkg::M_DY2_WX;
                        o_cmd.aop  = rri_pkg::A_LOAD;
                        o_cmd.st   = rri_pkg::ST_DEN;
                    end
                    4'd8: begin o_cmd.msel = rri_pkg::M_DX1_WY; o_cmd.aop = rri_pkg::A_SUB; end
                    4'd9: begin
                        o_cmd.msel = rri_pkg::M_DY1_WX;
                        o_cmd.aop  = rri_pkg::A_LOAD;
                        o_cmd.st   = rri_pkg::ST_NU;
                    end
                    4'd10: o_cmd.aop = rri_pkg::A_SUB;
                    4'd11: o_cmd.st = rri_pkg::ST_NV;
                    4'd12: begin
                        o_cmd.st = rri_pkg::ST_NORM;
                        if (i_sts.den_zero) begin
                            n_kind  = rri_pkg::OUT_ERROR;
                            n_emit  = '0;
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        n_pc = '0;
                        if (i_sts.in_range) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIVU;
                        end else begin
                            n_k = r_k + 2'd1;
                            if (r_k == 2'd3) n_state = S_FIN;
                        end
                    end
                endcase
            end
            S_DIVU: begin
                n_pc = '0;
                if (i_sts.div_done) begin
                    o_cmd.st = rri_pkg::ST_UQ;
                    n_state  = S_HIT;
                end
            end
            S_HIT: begin
                case (r_pc)
                    4'd0: o_cmd.msel = rri_pkg::M_DX1_UQ;
                    4'd1: begin o_cmd.msel = rri_pkg::M_DY1_UQ; o_cmd.st = rri_pkg::ST_HX; end
                    default: begin
                        o_cmd.st        = rri_pkg::ST_HY;
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel_v = 1'b1;
                        n_state         = S_DIVV;
                    end
                endcase
            end
            S_DIVV: begin
                n_pc = '0;
                o_cmd.div_sel_v = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.st = rri_pkg::ST_KEY;
                    n_k      = r_k + 2'd1;
                    n_state  = (r_k == 2'd3) ? S_FIN : S_BORD;
                end
            end
            S_FIN: begin
                n_pc   = '0;
                n_emit = '0;
                n_kind = rri_pkg::OUT_POINT;
                if (i_sts.hit_count == 3'd0) begin
                    n_kind  = rri_pkg::OUT_NOHIT;
                    n_state = S_EMIT;
                end else if (i_sts.sorted) begin
                    n_state = S_SORT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SORT: begin
                o_cmd.sort_en  = 1'b1;
                o_cmd.sort_odd = r_pc[0];
                if (r_pc == 4'd3) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.out_kind = r_kind;
                o_cmd.out_last = (r_kind != rri_pkg::OUT_POINT)
                              || (({1'b0, r_emit} + 3'd1) == i_sts.hit_count);
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (o_cmd.out_last) n_state = S_IDLE;
                    else n_emit = r_emit + 2'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_valid) begin
            n_state = S_BUILD;
            n_pc    = '0;
            n_k     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BUILD;
            r_pc    <= '0;
            r_k     <= '0;
            r_emit  <= '0;
            r_kind  <= rri_pkg::OUT_POINT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_k     <= n_k;
            r_emit  <= n_emit;
            r_kind  <= n_kind;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result word loaded over a pending word");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");
    a_accept_bord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_BORD && r_pc == 4'd0 && r_k == 2'd0))
        else $error("accepted ray did not start border solve");
    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BORD && r_pc == 4'd13) |-> !i_sts.den_zero)
        else $error("range test reached with zero denominator");
endmodule
`default_nettype wire

/* rtl/ray_rectangle_intersection_core.sv */
// Top level of the ray segment / rotated rectangle intersection core.
//
//  channel  dir  handshake                    payload
//  s        in   i_s_tvalid / o_s_tready      i_s_tdata (ray), i_s_tuser (nearest_first)
//  m        out  o_m_tvalid / i_m_tready      o_m_tdata (hit), o_m_tuser (outcome), o_m_tlast
//  cfg      in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Each kept border runs two serial divisions, and output stalls lengthen the work on a ray;
// no new ray is taken until the last result word of the current one has been loaded.
// Reset and every config write start a corner build over all four corners; no ray is taken meanwhile.
// Results go through one output register; a stalled output holds the next word.
`default_nettype none
module ray_rectangle_intersection_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // ray_start_x, ray_start_y, ray_end_x, ray_end_y
    input  wire logic [0:0]   i_s_tuser,   // nearest_first
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [71:0]       o_m_tdata,   // hit_x, hit_y, border_index, zero pad
    output logic [1:0]        o_m_tuser,   // outcome
    output logic              o_m_tlast,   // last_of_run
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    rri_pkg::t_cmd w_cmd;
    rri_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    rri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rri_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the ray segment / rotated rectangle intersection core.
`default_nettype none
module tb_top;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         outcome;
        logic [1:0]         border;
        logic               last;
    } t_hit;

    typedef struct {
        logic [31:0] sx, sy, ex, ey;
        logic        nearest;
        bit          typed;
        t_hit        want;
    } t_ray_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic [0:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [71:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    ray_rectangle_intersection_core dut (.*);

    localparam int WATCHDOG_LIMIT = 20000;

    // rectangle shadow copy
    longint rect_cx, rect_cy, rect_sx, rect_sy, rect_cos, rect_sin;
    longint corner_x[4], corner_y[4];

    t_hit   hit_queue[$];
    int     fail_count;
    int     idle_cycles;
    bit     stim_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic void build_rect();
        int sgx[4], sgy[4];
        longint lx, ly;
        sgx = '{-1, 1, 1, -1};
        sgy = '{-1, -1, 1, 1};
        for (int k = 0; k < 4; k++) begin
            lx = sgx[k] * rect_sx;
            ly = sgy[k] * rect_sy;
            corner_x[k] = sat32(rect_cx + round_shift(rect_cos * lx - rect_sin * ly, 17));
            corner_y[k] = sat32(rect_cy + round_shift(rect_sin * lx + rect_cos * ly, 17));
        end
    endfunction

    // num/den in Q1.30, rounded half up; 0 <= num <= den
    function automatic longint unsigned param_quot(logic signed [127:0] num,
                                                   logic signed [127:0] den);
        longint unsigned q;
        q = 0;
        if (num >= den) begin
            q = 1;
            num = num - den;
        end
        for (int i = 0; i < 31; i++) begin
            num = num <<< 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q = q | 1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    function automatic void predict_hits(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                                         logic [31:0] ey, logic nearest);
        longint px, py, dx2, dy2, ax, ay, dx1, dy1, wx, wy;
        logic signed [127:0] den, nu, nv;
        longint unsigned uq;
        longint unsigned keys[4];
        t_hit found[4];
        t_hit th;
        longint unsigned tk;
        int n;
        n = 0;
        px = longint'(signed'(sx));
        py = longint'(signed'(sy));
        dx2 = longint'(signed'(ex)) - px;
        dy2 = longint'(signed'(ey)) - py;
        for (int b = 0; b < 4; b++) begin
            ax = corner_x[b];
            ay = corner_y[b];
            dx1 = corner_x[(b + 1) % 4] - ax;
            dy1 = corner_y[(b + 1) % 4] - ay;
            wx = ax - px;
            wy = ay - py;
            den = 128'(dx1) * 128'(dy2) - 128'(dy1) * 128'(dx2);
            if (den == 0) begin
                hit_queue.push_back('{0, 0, rri_pkg::OUT_ERROR, 2'(b), 1'b1});
                return;
            end
            nu = 128'(dx2) * 128'(wy) - 128'(dy2) * 128'(wx);
            nv = 128'(dx1) * 128'(wy) - 128'(dy1) * 128'(wx);
            if (den < 0) begin
                den = -den;
                nu = -nu;
                nv = -nv;
            end
            if (nu < 0 || nv < 0 || nu > den || nv > den) continue;
            uq = param_quot(nu, den);
            found[n].x = 32'(sat32(ax + round_shift(dx1 * longint'(uq), 30)));
            found[n].y = 32'(sat32(ay + round_shift(dy1 * longint'(uq), 30)));
            found[n].outcome = rri_pkg::OUT_POINT;
            found[n].border = 2'(b);
            found[n].last = 1'b0;
            keys[n] = param_quot(nv, den);
            n++;
        end
        if (n == 0) begin
            hit_queue.push_back('{0, 0, rri_pkg::OUT_NOHIT, 2'd0, 1'b1});
            return;
        end
        if (nearest) begin
            for (int i = 1; i < n; i++) begin
                for (int j = i; j > 0 && keys[j] < keys[j - 1]; j--) begin
                    th = found[j]; found[j] = found[j - 1]; found[j - 1] = th;
                    tk = keys[j]; keys[j] = keys[j - 1]; keys[j - 1] = tk;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            hit_queue.push_back(found[i]);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    // result side: random stalls, compare against oldest expectation
    initial begin
        t_hit got, want;
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got = '{o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser, o_m_tdata[65:64],
                    o_m_tlast};
            if (hit_queue.size() == 0) begin
                report_mismatch("unexpected word", 64'(got), 64'd0);
            end else begin
                want = hit_queue.pop_front();
                if (got.x != want.x) report_mismatch("hit_x", got.x, want.x);
                if (got.y != want.y) report_mismatch("hit_y", got.y, want.y);
                if (got.outcome != want.outcome)
                    report_mismatch("outcome", got.outcome, want.outcome);
                if (got.border != want.border)
                    report_mismatch("border_index", got.border, want.border);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
            @(negedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
                $display("watchdog timeout");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            rri_pkg::CFG_CENTER_X: rect_cx = longint'(signed'(value));
            rri_pkg::CFG_CENTER_Y: rect_cy = longint'(signed'(value));
            rri_pkg::CFG_SIZE_X:   rect_sx = longint'(value[30:0]);
            rri_pkg::CFG_SIZE_Y:   rect_sy = longint'(value[30:0]);
            rri_pkg::CFG_COS:      rect_cos = longint'(signed'(value[17:0]));
            rri_pkg::CFG_SIN:      rect_sin = longint'(signed'(value[17:0]));
            default: ;
        endcase
        build_rect();
    endtask

    // called right after a ray word, at a falling edge
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_rect(logic [31:0] cx, logic [31:0] cy, logic [31:0] sx,
                            logic [31:0] sy, logic [17:0] c, logic [17:0] s);
        wait_drained();
        write_reg(rri_pkg::CFG_CENTER_X, cx);
        write_reg(rri_pkg::CFG_CENTER_Y, cy);
        write_reg(rri_pkg::CFG_SIZE_X, sx);
        write_reg(rri_pkg::CFG_SIZE_Y, sy);
        write_reg(rri_pkg::CFG_COS, {{14{c[17]}}, c});
        write_reg(rri_pkg::CFG_SIN, {{14{s[17]}}, s});
    endtask

    // valid stays up after acceptance until the next word or the next gap
    task automatic send_ray(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                            logic [31:0] ey, logic nearest);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ey, ex, sy, sx};
        i_s_tuser  <= nearest;
        do @(posedge i_clk); while (!o_s_tready);
        predict_hits(sx, sy, ex, ey, nearest);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    t_ray_row ray_rows[$];
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] HALF = 32'h0000_8000;

    initial begin
        int mode;
        logic [31:0] sx, sy, ex, ey;
        stim_done = 1'b0;
        fail_count = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rect_cx = 0; rect_cy = 0; rect_sx = 65536; rect_sy = 65536;
        rect_cos = 65536; rect_sin = 0;
        build_rect();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows against the reset square, corners at +-0.5
        ray_rows = '{
            '{-ONE, 0, ONE, 0, 1'b0, 1'b1, '{-32'sh8000, 0, rri_pkg::OUT_ERROR, 2'd0, 1'b1}},
            '{0, 0, 0, 0, 1'b0, 1'b1, '{0, 0, rri_pkg::OUT_ERROR, 2'd0, 1'b1}},
            '{-ONE, -ONE, ONE, ONE, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
            '{-ONE, -ONE, ONE, ONE, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
            '{ONE, ONE, -ONE, -ONE, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
            '{3 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 1'b0, 1'b1,
              '{0, 0, rri_pkg::OUT_NOHIT, 2'd0, 1'b1}},
            '{0, 0, HALF, ONE, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
            '{-ONE, -(HALF / 2), ONE, HALF, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
            '{-ONE, -(HALF / 2), ONE, HALF, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
            '{32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1, 1'b0,
              '{0, 0, 0, 0, 0}},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0,
              '{0, 0, 0, 0, 0}},
            '{-HALF, -ONE, HALF, ONE, 1'b1, 1'b0, '{0, 0, 0, 0, 0}}
        };
        // first row gives parallel error on border 0 with hit 0
        ray_rows[0].want.x = 0;
        foreach (ray_rows[r]) begin
            send_ray(ray_rows[r].sx, ray_rows[r].sy, ray_rows[r].ex, ray_rows[r].ey,
                     ray_rows[r].nearest);
            if (ray_rows[r].typed) begin
                void'(hit_queue.pop_back());
                hit_queue.push_back(ray_rows[r].want);
            end
        end

        // extremes: degenerate size, huge rotated box with out-of-range trig, saturation
        set_rect(0, 0, 0, ONE, 18'd65536, 18'd0);
        send_ray(-ONE, 0, ONE, 0, 1'b0);
        set_rect(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 18'h20000, 18'h1FFFF);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_rect(0, 0, 2 * ONE, ONE, 18'd46341, 18'd46341);
                1: set_rect(HALF, -HALF, 3 * ONE, 2 * ONE, 18'h3FFFF & -18'd39322,
                            18'd52429);
                2: set_rect($urandom(), $urandom(), $urandom(), $urandom(),
                            18'($urandom()), 18'($urandom()));
                3: set_rect(-ONE, ONE, ONE, 4 * ONE, -18'sd65536, 18'd0);
                default: set_rect(0, 0, 32'h7FFF_FFFF, 0, 18'd0, 18'd65536);
            endcase
            for (int i = 0; i < 40; i++) begin
                mode = $urandom_range(0, 9) == 0 ? 0 : (phase == 2 ? 0 : $urandom_range(1, 2));
                sx = rand_coord(mode);
                sy = rand_coord(mode);
                ex = rand_coord(mode);
                ey = rand_coord(mode);
                if (phase != 2) begin
                    sx = sx + 32'(rect_cx);
                    sy = sy + 32'(rect_cy);
                    ex = ex + 32'(rect_cx);
                    ey = ey + 32'(rect_cy);
                end
                send_ray(sx, sy, ex, ey, 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        stim_done = 1'b1;
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/rri_pkg.sv
rtl/rri_div.sv
rtl/rri_datapath.sv
rtl/rri_ctrl.sv
rtl/ray_rectangle_intersection_core.sv
verif/tb_top.sv
